/* design/dbdf_pkg.sv */
`timescale 1ns / 1ps

package dbdf_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned HeaderLen = 5;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCORE_THRESHOLD = 3'd0,
    CFG_SCALE_X         = 3'd1,
    CFG_SCALE_Y         = 3'd2,
    CFG_MAX_BOXES       = 3'd3,
    CFG_CLASS_COUNT     = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    EV_CLEAR = 1'b0,
    EV_ROW   = 1'b1
  } ev_e;

  typedef struct packed {
    logic signed [15:0] value;
    logic               frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] left;
    logic signed [23:0] top;
    logic signed [23:0] right;
    logic signed [23:0] bottom;
    logic [14:0]        score;
    logic [6:0]         class_id;
  } out_item_t;

  // Row-end or frame-clear event leaving the accumulator.
  typedef struct packed {
    ev_e                kind;
    logic               obj_ok;
    logic [6:0]         cls;
    logic signed [15:0] obj;
    logic signed [15:0] best;
    logic signed [17:0] l2;
    logic signed [17:0] t2;
    logic signed [17:0] r2;
    logic signed [17:0] b2;
  } row_ev_t;

  // Event after the multiplier stage.
  typedef struct packed {
    ev_e                kind;
    logic               obj_ok;
    logic [6:0]         cls;
    logic signed [31:0] prod;
    logic signed [34:0] pl;
    logic signed [34:0] pt;
    logic signed [34:0] pr;
    logic signed [34:0] pb;
  } prod_ev_t;

endpackage

/* design/dbdf_row_acc.sv */
`timescale 1ns / 1ps

module dbdf_row_acc
  import dbdf_pkg::*;
#(
  parameter int unsigned MAX_CLASSES = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  input  logic [14:0] score_threshold_i,
  input  logic [7:0]  class_count_i,
  output logic        a_valid_o,
  input  logic        a_ready_i,
  output row_ev_t     a_data_o
);

  localparam int unsigned PosW = $clog2(MAX_CLASSES + HeaderLen);
  localparam logic [7:0] MaxCls = 8'(MAX_CLASSES);
  localparam logic [PosW-1:0] PosObj = PosW'(HeaderLen - 1);

  logic [PosW-1:0]    pos_q, pos_d, pos_eff, cidx;
  logic signed [15:0] geo_q [4];
  logic signed [15:0] obj_q, best_q, best_d;
  logic [6:0]         bcls_q, bcls_d;
  logic               a_valid_q;
  row_ev_t            a_q, a_d;
  logic [7:0]         cls_eff;
  logic               accept, row_last, take, a_load;
  logic signed [15:0] v;

  assign v       = in_data_i.value;
  assign accept  = in_valid_i && in_ready_o;
  assign pos_eff = in_data_i.frame_start ? '0 : pos_q;
  assign cidx    = pos_eff - PosW'(HeaderLen);

  always_comb begin
    if (class_count_i == 8'd0) begin
      cls_eff = 8'd1;
    end else if (class_count_i > MaxCls) begin
      cls_eff = MaxCls;
    end else begin
      cls_eff = class_count_i;
    end
  end

  always_comb begin
    take     = (pos_eff == PosW'(HeaderLen)) || (v > best_q);
    best_d   = take ? v : best_q;
    bcls_d   = take ? 7'(cidx) : bcls_q;
    row_last = (pos_eff > PosObj) &&
               (9'(pos_eff) >= 9'(cls_eff) + 9'(HeaderLen - 1));
    if (pos_eff <= PosObj) begin
      pos_d = pos_eff + 1'b1;
    end else if (row_last) begin
      pos_d = '0;
    end else begin
      pos_d = pos_eff + 1'b1;
    end
  end

  assign a_load = accept && (in_data_i.frame_start || row_last);

  always_comb begin
    a_d        = a_q;
    a_d.kind   = in_data_i.frame_start ? EV_CLEAR : EV_ROW;
    a_d.obj_ok = obj_q >= $signed({1'b0, score_threshold_i});
    a_d.cls    = bcls_d;
    a_d.obj    = obj_q;
    a_d.best   = best_d;
    a_d.l2     = {geo_q[0][15], geo_q[0], 1'b0} - {{2{geo_q[2][15]}}, geo_q[2]};
    a_d.r2     = {geo_q[0][15], geo_q[0], 1'b0} + {{2{geo_q[2][15]}}, geo_q[2]};
    a_d.t2     = {geo_q[1][15], geo_q[1], 1'b0} - {{2{geo_q[3][15]}}, geo_q[3]};
    a_d.b2     = {geo_q[1][15], geo_q[1], 1'b0} + {{2{geo_q[3][15]}}, geo_q[3]};
  end

  assign in_ready_o = !a_valid_q || a_ready_i;
  assign a_valid_o  = a_valid_q;
  assign a_data_o   = a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      geo_q     <= '{default: '0};
      obj_q     <= '0;
      best_q    <= '0;
      bcls_q    <= '0;
      a_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pos_q <= pos_d;
        if (pos_eff < PosObj) begin
          geo_q[pos_eff[1:0]] <= v;
        end else if (pos_eff == PosObj) begin
          obj_q <= v;
        end else begin
          best_q <= best_d;
          bcls_q <= bcls_d;
        end
      end
      if (a_load) begin
        a_valid_q <= 1'b1;
      end else if (a_ready_i) begin
        a_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      a_q <= a_d;
    end
  end

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    9'(pos_q) <= 9'(MAX_CLASSES + HeaderLen - 1))
    else $error("row position past the last class");

  a_event_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !a_ready_i |=> a_valid_q && $stable(a_q))
    else $error("pending row event changed while stalled");

  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !a_valid_q |-> in_ready_o)
    else $error("input stalled with an empty event stage");

endmodule

/* design/dbdf_box_mul.sv */
`timescale 1ns / 1ps

module dbdf_box_mul
  import dbdf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        a_valid_i,
  output logic        a_ready_o,
  input  row_ev_t     a_data_i,
  input  logic [15:0] scale_x_i,
  input  logic [15:0] scale_y_i,
  output logic        b_valid_o,
  input  logic        b_ready_i,
  output prod_ev_t    b_data_o
);

  logic     b_valid_q, b_load;
  prod_ev_t b_q, b_d;

  assign a_ready_o = !b_valid_q || b_ready_i;
  assign b_load    = a_valid_i && a_ready_o;

  always_comb begin
    b_d.kind   = a_data_i.kind;
    b_d.obj_ok = a_data_i.obj_ok;
    b_d.cls    = a_data_i.cls;
    b_d.prod   = a_data_i.obj * a_data_i.best;
    b_d.pl     = a_data_i.l2 * $signed({1'b0, scale_x_i});
    b_d.pr     = a_data_i.r2 * $signed({1'b0, scale_x_i});
    b_d.pt     = a_data_i.t2 * $signed({1'b0, scale_y_i});
    b_d.pb     = a_data_i.b2 * $signed({1'b0, scale_y_i});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_load) begin
      b_valid_q <= 1'b1;
    end else if (b_ready_i) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_load) begin
      b_q <= b_d;
    end
  end

  assign b_valid_o = b_valid_q;
  assign b_data_o  = b_q;

endmodule

/* design/dbdf_emit.sv */
`timescale 1ns / 1ps

module dbdf_emit
  import dbdf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        b_valid_i,
  output logic        b_ready_o,
  input  prod_ev_t    b_data_i,
  input  logic [14:0] score_threshold_i,
  input  logic [15:0] max_boxes_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o
);

  logic               o_valid_q, stopped_q, b_go, pass;
  logic [16:0]        cnt_q, cnt_inc;
  logic signed [16:0] conf;
  out_item_t          out_q, out_d;

  function automatic logic signed [23:0] edge_px(input logic signed [34:0] p);
    logic signed [34:0] s;
    s = (p + 35'sd4096) >>> 13;
    if (s > 35'sd8388607) begin
      return 24'sh7fffff;
    end else if (s < -35'sd8388608) begin
      return 24'sh800000;
    end
    return s[23:0];
  endfunction

  assign b_ready_o = !o_valid_q || out_ready_i;
  assign b_go      = b_valid_i && b_ready_o;
  assign conf      = 17'(b_data_i.prod >>> 15);
  assign cnt_inc   = cnt_q + 17'd1;
  assign pass      = (b_data_i.kind == EV_ROW) && !stopped_q && b_data_i.obj_ok &&
                     (conf >= $signed({2'b00, score_threshold_i}));

  always_comb begin
    out_d.left     = edge_px(b_data_i.pl);
    out_d.top      = edge_px(b_data_i.pt);
    out_d.right    = edge_px(b_data_i.pr);
    out_d.bottom   = edge_px(b_data_i.pb);
    out_d.score    = conf[14:0];
    out_d.class_id = b_data_i.cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
      cnt_q     <= '0;
      stopped_q <= 1'b0;
    end else begin
      if (b_go && pass) begin
        o_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        o_valid_q <= 1'b0;
      end
      if (b_go) begin
        if (b_data_i.kind == EV_CLEAR) begin
          cnt_q     <= '0;
          stopped_q <= 1'b0;
        end else if (pass) begin
          cnt_q <= cnt_inc;
          if (cnt_inc > {1'b0, max_boxes_i}) begin
            stopped_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_go && pass) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o  = out_q;

  a_cnt_only_on_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_go && (b_data_i.kind == EV_ROW) && !pass |=> cnt_q == $past(cnt_q))
    else $error("box count moved without an emitted box");

  a_stop_needs_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(stopped_q) |-> cnt_q > {1'b0, max_boxes_i})
    else $error("frame stopped below the box limit");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_valid_q && !out_ready_i |=> o_valid_q && $stable(out_q))
    else $error("pending box changed while stalled");

endmodule

/* design/detector_box_decode_filter_top.sv */
`timescale 1ns / 1ps

// Detector row decoder: one row element per input beat (cx, cy, w, h,
// objectness, then class_count class scores). frame_start on the first
// element of a frame clears the box count and drops any partial row.
// Output beats carry a scaled corner box, the combined score and the
// class index, only for rows that pass both score thresholds until the
// frame's box count exceeds max_boxes. Input takes one beat per cycle
// while in_ready_o is high. A row-end event passes an event stage, a
// multiplier stage (one 16x16 and four 18x17 signed products in
// parallel) and the output register before the box shows on
// out_valid_o. Rows are at least six beats long, so the three event
// stages never fill in steady state; in_ready_o only drops when all
// three hold events and the receiver stalls out_ready_i.
// Reset loads the register defaults (threshold 8192, scales 4096,
// max_boxes 4096, class_count 80), restarts the row at cx and empties
// the pipeline. Configuration writes take effect at once and should only
// be issued while no box is pending.
module detector_box_decode_filter_top
  import dbdf_pkg::*;
#(
  parameter int unsigned MAX_CLASSES = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [14:0] thr_q;
  logic [15:0] scale_x_q, scale_y_q, max_boxes_q;
  logic [7:0]  class_count_q;
  logic        a_valid, a_ready, b_valid, b_ready;
  row_ev_t     a_data;
  prod_ev_t    b_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q         <= 15'd8192;
      scale_x_q     <= 16'd4096;
      scale_y_q     <= 16'd4096;
      max_boxes_q   <= 16'd4096;
      class_count_q <= 8'd80;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SCORE_THRESHOLD: thr_q         <= cfg_data_i[14:0];
        CFG_SCALE_X:         scale_x_q     <= cfg_data_i;
        CFG_SCALE_Y:         scale_y_q     <= cfg_data_i;
        CFG_MAX_BOXES:       max_boxes_q   <= cfg_data_i;
        CFG_CLASS_COUNT:     class_count_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  dbdf_row_acc #(
    .MAX_CLASSES(MAX_CLASSES)
  ) u_row_acc (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .in_data_i         (in_data_i),
    .score_threshold_i (thr_q),
    .class_count_i     (class_count_q),
    .a_valid_o         (a_valid),
    .a_ready_i         (a_ready),
    .a_data_o          (a_data)
  );

  dbdf_box_mul u_box_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .a_valid_i (a_valid),
    .a_ready_o (a_ready),
    .a_data_i  (a_data),
    .scale_x_i (scale_x_q),
    .scale_y_i (scale_y_q),
    .b_valid_o (b_valid),
    .b_ready_i (b_ready),
    .b_data_o  (b_data)
  );

  dbdf_emit u_emit (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .b_valid_i         (b_valid),
    .b_ready_o         (b_ready),
    .b_data_i          (b_data),
    .score_threshold_i (thr_q),
    .max_boxes_i       (max_boxes_q),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_data_o        (out_data_o)
  );

endmodule

/* test/detector_box_decode_filter_top_tb.sv */
`timescale 1ns / 1ps

module detector_box_decode_filter_top_tb;
  import dbdf_pkg::*;

  localparam int MaxClasses = 128;
  localparam int CycleLimit = 300000;
  localparam int DrainCycles = 8;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_item_t            in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_data_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  in_item_t  beat_q[$];
  out_item_t box_q[$];
  out_item_t want;

  // register copies
  logic [14:0] thr_r = 15'd8192;
  logic [15:0] sx_r = 16'd4096;
  logic [15:0] sy_r = 16'd4096;
  logic [15:0] maxb_r = 16'd4096;
  logic [7:0]  ncls_r = 8'd80;

  // row decoder state
  int                 row_pos = 0;
  logic signed [15:0] geom[4] = '{default: '0};
  logic signed [15:0] obj_v = '0;
  logic signed [15:0] best_v = '0;
  logic [6:0]         best_cls = '0;
  logic [16:0]        boxes_out = '0;
  bit                 frame_full = 1'b0;

  int n_acc = 0;
  int n_err = 0;
  int n_cyc = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit no_idle = 1'b0;

  detector_box_decode_filter_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic signed [15:0] rnd16();
    logic [31:0] r;
    r = $urandom;
    return r[15:0];
  endfunction

  function automatic logic signed [23:0] scaled_corner(logic signed [15:0] ctr,
                                                       logic signed [15:0] ext,
                                                       bit minus, logic [15:0] scl);
    longint t, s, p;
    t = ctr;
    t = 2 * t;
    s = ext;
    t = minus ? t - s : t + s;
    s = scl;
    p = (t * s + 4096) >>> 13;
    if (p > 8388607) p = 8388607;
    if (p < -8388608) p = -8388608;
    return p[23:0];
  endfunction

  task automatic decode_beat(in_item_t b);
    int eff, c, thr_i, obj_i;
    longint prod, conf;
    out_item_t r;
    eff = (ncls_r == 0) ? 1 : ((ncls_r > MaxClasses) ? MaxClasses : ncls_r);
    if (b.frame_start) begin
      boxes_out = '0;
      frame_full = 1'b0;
      row_pos = 0;
    end
    if (row_pos < 4) begin
      geom[row_pos[1:0]] = b.value;
      row_pos = row_pos + 1;
      return;
    end
    if (row_pos == 4) begin
      obj_v = b.value;
      row_pos = 5;
      return;
    end
    c = row_pos - HeaderLen;
    if (c == 0 || b.value > best_v) begin
      best_v = b.value;
      best_cls = c[6:0];
    end
    if (c + 1 < eff) begin
      row_pos = row_pos + 1;
      return;
    end
    row_pos = 0;
    if (frame_full) return;
    thr_i = thr_r;
    obj_i = obj_v;
    if (obj_i < thr_i) return;
    prod = obj_v;
    conf = best_v;
    prod = prod * conf;
    if (prod < 0) return;
    conf = prod >>> 15;
    if (conf < thr_i) return;
    r.left = scaled_corner(geom[0], geom[2], 1'b1, sx_r);
    r.top = scaled_corner(geom[1], geom[3], 1'b1, sy_r);
    r.right = scaled_corner(geom[0], geom[2], 1'b0, sx_r);
    r.bottom = scaled_corner(geom[1], geom[3], 1'b0, sy_r);
    r.score = conf[14:0];
    r.class_id = best_cls;
    box_q = {box_q, r};
    boxes_out = boxes_out + 17'd1;
    if (boxes_out > maxb_r) frame_full = 1'b1;
  endtask

  task automatic push_beat(logic signed [15:0] v, logic fs);
    in_item_t b;
    b.value = v;
    b.frame_start = fs;
    beat_q = {beat_q, b};
  endtask

  task automatic queue_phase(int n_items, int nc_reg, int thr);
    int nc, cnt, len, win, pick;
    logic signed [15:0] top, sc;
    logic fs;
    bit restart;
    nc = (nc_reg == 0) ? 1 : ((nc_reg > MaxClasses) ? MaxClasses : nc_reg);
    cnt = 0;
    restart = 1'b1;
    while (cnt < n_items) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        // cut the row short
        len = $urandom_range(4 + nc, 1);
        for (int i = 0; i < len; i++) push_beat(rnd16(), restart && i == 0);
        cnt += len;
        restart = 1'b1;
      end else if (pick < 12) begin
        fs = 1'($urandom_range(1));
        push_beat(rnd16(), fs);
        cnt++;
        restart = 1'b1;
      end else begin
        push_beat(rnd16(), restart || ($urandom_range(99) < 8));
        repeat (3) push_beat(rnd16(), 1'b0);
        if ($urandom_range(99) < 80) sc = 16'($urandom_range(32767, thr));
        else sc = rnd16();
        push_beat(sc, 1'b0);
        top = 16'($urandom_range(32767, 24000));
        win = $urandom_range(nc - 1);
        for (int c = 0; c < nc; c++) begin
          if (c == win || $urandom_range(9) == 0) sc = top;
          else if ($urandom_range(1)) sc = rnd16();
          else sc = 16'($urandom_range(top));
          push_beat(sc, 1'b0);
        end
        cnt += 5 + nc;
        restart = 1'b0;
      end
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, int val);
    logic [31:0] v;
    v = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v[15:0];
    case (idx)
      CFG_SCORE_THRESHOLD: thr_r = v[14:0];
      CFG_SCALE_X:         sx_r = v[15:0];
      CFG_SCALE_Y:         sy_r = v[15:0];
      CFG_MAX_BOXES:       maxb_r = v[15:0];
      CFG_CLASS_COUNT:     ncls_r = v[7:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (beat_q.size() != 0 || in_valid_i || box_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic configure(int thr, int sx, int sy, int mb, int nc, bit calm);
    wait_drained();
    write_reg(CFG_SCORE_THRESHOLD, thr);
    write_reg(CFG_SCALE_X, sx);
    write_reg(CFG_SCALE_Y, sy);
    write_reg(CFG_MAX_BOXES, mb);
    write_reg(CFG_CLASS_COUNT, nc);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    no_idle <= calm;
    @(negedge clk_i);
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      n_err++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        decode_beat(in_data_i);
        n_acc <= n_acc + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (beat_q.size() != 0 && (no_idle || $urandom_range(99) >= 38)) begin
          in_valid_i <= 1'b1;
          in_data_i <= beat_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (!hold_done && n_acc >= 120) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= no_idle || ($urandom_range(99) >= 38);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (box_q.size() == 0) begin
        $error("box beat with no pending expectation");
        n_err++;
      end else begin
        want = box_q.pop_front();
        check_field("left", want.left, out_data_o.left);
        check_field("top", want.top, out_data_o.top);
        check_field("right", want.right, out_data_o.right);
        check_field("bottom", want.bottom, out_data_o.bottom);
        check_field("score", want.score, out_data_o.score);
        check_field("class_id", want.class_id, out_data_o.class_id);
      end
    end
  end

  always @(posedge clk_i) begin
    n_cyc <= n_cyc + 1;
    if (n_cyc == CycleLimit) begin
      $display("detector_box_decode_filter_top_tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    configure(8192, 4096, 0, 0, 0, 1'b0);
    push_beat(16'sh7fff, 1'b1);
    push_beat(-16'sd32768, 1'b0);
    push_beat(16'sh7fff, 1'b0);
    push_beat(-16'sd32768, 1'b0);
    push_beat(16'sh7fff, 1'b0);
    push_beat(16'sh7fff, 1'b0);
    // frame is stopped now
    push_beat(16'sd100, 1'b0);
    push_beat(16'sd200, 1'b0);
    push_beat(16'sd50, 1'b0);
    push_beat(16'sd60, 1'b0);
    push_beat(16'sd30000, 1'b0);
    push_beat(16'sd30000, 1'b0);
    // drop a partial row
    push_beat(16'sd1234, 1'b1);
    push_beat(-16'sd16, 1'b1);
    push_beat(16'sd16, 1'b0);
    push_beat(16'sd0, 1'b0);
    push_beat(16'sd0, 1'b0);
    push_beat(-16'sd32768, 1'b0);
    push_beat(16'sh7fff, 1'b0);
    push_beat(16'sd0, 1'b0);
    push_beat(16'sd0, 1'b0);
    push_beat(16'sd0, 1'b0);
    push_beat(16'sd0, 1'b0);
    push_beat(16'sh7fff, 1'b0);
    push_beat(-16'sd32768, 1'b0);

    configure(8192, 4096, 4096, 65535, 3, 1'b0);
    queue_phase(220, 3, 8192);
    configure(0, 65535, 1, 3, 1, 1'b1);
    queue_phase(150, 1, 0);
    configure(32767, 1, 65535, 65535, 2, 1'b0);
    queue_phase(50, 2, 32767);
    configure(6000, 5000, 3000, 65535, 128, 1'b0);
    queue_phase(120, 128, 6000);
    configure(16384, 8192, 2048, 1, 255, 1'b0);
    queue_phase(120, 255, 16384);
    configure(3000, 40000, 12345, 4, 5, 1'b0);
    queue_phase(250, 5, 3000);

    wait_drained();
    if (n_err == 0) begin
      $display("detector_box_decode_filter_top_tb OK");
    end else begin
      $display("detector_box_decode_filter_top_tb NOT OK");
    end
    $finish;
  end

endmodule
